>>> rtl/chm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chm_pkg: shared types and codes for the chained hash map
// Opcodes, status codes, sequencer states and the modulo unit handshake.
// ----------------------------------------------------------------------------
package chm_pkg;

	localparam int KeyW = 31;
	localparam int ValW = 32;
	localparam int CntW = 9;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_SEARCH = 2'd2,
		OP_NOP    = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOTFOUND = 2'd1,
		ST_FULL     = 2'd2
	} status_t;

	localparam logic [ValW-1:0] MissValue = 32'h8000_0000;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MOD,
		S_HEAD,
		S_HEADW,
		S_RD,
		S_RDW,
		S_CMP,
		S_ALLOC,
		S_ALLOCW,
		S_LINK,
		S_UNLINK,
		S_FREE,
		S_OUT
	} state_t;

	// modulo unit control
	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} mod_ctl_t;

endpackage

>>> rtl/chm_mod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chm_mod: restoring remainder unit
// Reduces a 31-bit key modulo a DivW-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module chm_mod #(
	parameter int DivW = 9
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [30:0]         dividend,
	input  logic [DivW-1:0]     divisor,
	output logic                busy,
	output logic                done,
	output logic [DivW-1:0]     remainder
);
	import chm_pkg::*;

	logic [KeyW-1:0] num_q;
	logic [DivW-1:0] den_q;
	logic [DivW:0]   rem_q;
	logic [4:0]      cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [DivW:0]   trial;

	// shift in next key bit and subtract if it fits
	assign trial = {rem_q[DivW-1:0], num_q[KeyW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(KeyW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[KeyW-2:0], 1'b0};
			if (trial >= {1'b0, den_q}) rem_q <= trial - {1'b0, den_q};
			else rem_q <= trial;
		end
	end

	assign busy      = busy_q;
	assign done      = done_q;
	assign remainder = rem_q[DivW-1:0];

endmodule

>>> rtl/chm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chm_ctrl: operation sequencer with bucket and node memories
// Walks one chain a node at a time and applies insert, remove or search.
// ----------------------------------------------------------------------------
module chm_ctrl #(
	parameter int MaxBuckets = 256,
	parameter int PoolNodes  = 1024
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [1:0]                in_op,
	input  logic [30:0]               in_key,
	input  logic [31:0]               in_val,
	output chm_pkg::mod_ctl_t         mod_ctl,
	input  logic                      mod_busy,
	input  logic                      mod_done,
	input  logic [$clog2(MaxBuckets+1)-1:0] mod_rem,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [1:0]                out_status,
	output logic [31:0]               out_value
);
	import chm_pkg::*;

	localparam int BW = (MaxBuckets > 1) ? $clog2(MaxBuckets) : 1;
	localparam int NW = $clog2(PoolNodes + 1);
	localparam int IW = (PoolNodes > 1) ? $clog2(PoolNodes) : 1;
	localparam logic [NW-1:0] Nil = NW'(PoolNodes);
	localparam int SW = 17;

	state_t state_q, state_d;

	// bucket heads: memory with clearing pass after reset
	logic [NW-1:0] heads [MaxBuckets];
	logic [KeyW-1:0] keys [PoolNodes];
	logic [ValW-1:0] vals [PoolNodes];
	logic [NW-1:0]   links [PoolNodes];

	logic [1:0]      op_q;
	logic [KeyW-1:0] key_q;
	logic [ValW-1:0] val_q;
	logic [BW-1:0]   bkt_q;
	logic [NW-1:0]   cur_q, prev_q, free_q, fresh_q, head_rd_q;
	logic [KeyW-1:0] key_rd_q;
	logic [ValW-1:0] val_rd_q;
	logic [NW-1:0]   link_rd_q;
	logic [SW-1:0]   steps_q;
	logic            clr_q;
	logic [BW:0]     clr_cnt_q;
	logic [1:0]      st_q;
	logic [ValW-1:0] res_q;
	logic            hit;

	assign hit = (key_rd_q == key_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid && !clr_q)
					state_d = (in_op == OP_NOP) ? S_OUT : S_MOD;
			end
			S_MOD:    if (mod_done) state_d = S_HEAD;
			S_HEAD:   state_d = S_HEADW;
			S_HEADW:  state_d = S_RD;
			S_RD: begin
				if (cur_q >= Nil || steps_q >= SW'(PoolNodes))
					state_d = (op_q == OP_INSERT) ? S_ALLOC : S_OUT;
				else state_d = S_RDW;
			end
			S_RDW:    state_d = S_CMP;
			S_CMP: begin
				if (hit) state_d = (op_q == OP_REMOVE) ? S_UNLINK : S_OUT;
				else state_d = S_RD;
			end
			S_ALLOC:  state_d = S_ALLOCW;
			S_ALLOCW: state_d = S_LINK;
			S_LINK:   state_d = S_OUT;
			S_UNLINK: state_d = S_FREE;
			S_FREE:   state_d = S_OUT;
			S_OUT:    if (out_ready) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready      = (state_q == S_IDLE) && !clr_q;
		mod_ctl.start = (state_q == S_IDLE) && in_valid && !clr_q && (in_op != OP_NOP);
		mod_ctl.busy  = mod_busy;
		mod_ctl.done  = mod_done;
		out_valid     = (state_q == S_OUT);
		out_status    = st_q;
		out_value     = res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			free_q    <= Nil;
			fresh_q   <= '0;
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == (BW+1)'(MaxBuckets - 1)) clr_q <= 1'b0;
			end
			// take a never-used node only when the free list is empty
			if (state_q == S_ALLOC && free_q >= Nil && fresh_q < Nil)
				fresh_q <= fresh_q + 1'b1;
			if (state_q == S_ALLOCW && free_q < Nil) free_q <= link_rd_q;
			if (state_q == S_FREE) free_q <= cur_q;
		end
	end

	// datapath and memories
	always_ff @(posedge clk) begin
		if (clr_q) heads[clr_cnt_q[BW-1:0]] <= Nil;
		case (state_q)
			S_IDLE: begin
				op_q  <= in_op;
				key_q <= in_key;
				val_q <= in_val;
				st_q  <= ST_OK;
				res_q <= '0;
			end
			S_MOD: bkt_q <= mod_rem[BW-1:0];
			S_HEAD: head_rd_q <= heads[bkt_q];
			S_HEADW: begin
				cur_q   <= head_rd_q;
				prev_q  <= Nil;
				steps_q <= '0;
			end
			S_RD: begin
				key_rd_q  <= keys[cur_q[IW-1:0]];
				val_rd_q  <= vals[cur_q[IW-1:0]];
				link_rd_q <= links[cur_q[IW-1:0]];
				if (cur_q >= Nil || steps_q >= SW'(PoolNodes)) begin
					if (op_q != OP_INSERT) st_q <= ST_NOTFOUND;
					if (op_q == OP_SEARCH) res_q <= MissValue;
				end
			end
			S_CMP: begin
				if (hit) begin
					if (op_q == OP_INSERT) vals[cur_q[IW-1:0]] <= val_q;
					if (op_q == OP_SEARCH) res_q <= val_rd_q;
				end else begin
					prev_q  <= cur_q;
					cur_q   <= link_rd_q;
					steps_q <= steps_q + 1'b1;
				end
			end
			S_ALLOC: begin
				if (free_q < Nil) cur_q <= free_q;
				else if (fresh_q < Nil) cur_q <= fresh_q;
				else cur_q <= Nil;
				link_rd_q <= links[free_q[IW-1:0]];
			end
			S_LINK: begin
				if (cur_q >= Nil) st_q <= ST_FULL;
				else begin
					keys[cur_q[IW-1:0]]  <= key_q;
					vals[cur_q[IW-1:0]]  <= val_q;
					links[cur_q[IW-1:0]] <= head_rd_q;
					heads[bkt_q]         <= cur_q;
				end
			end
			S_UNLINK: begin
				if (prev_q >= Nil) heads[bkt_q] <= link_rd_q;
				else links[prev_q[IW-1:0]] <= link_rd_q;
			end
			// released node goes on top of the free list
			S_FREE: links[cur_q[IW-1:0]] <= free_q;
			default: ;
		endcase
	end

endmodule

>>> rtl/chained_hash_map_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_map_unit: key/value map with separately chained buckets
// Insert, remove and search over a fixed pool of nodes.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request: opcode, key and value. m_axis returns one
//   result per request: status and found value.
//   cfg_valid/cfg_ready write the bucket count; the count is sampled when a
//   request starts, so write it only while no request is in flight.
// Timing: a request first runs a bit-serial key modulo, then reads the
//   bucket head and walks the chain one node at a time. An opcode three
//   request answers on the next cycle. One request is in flight at a
//   time; the next is taken in the cycle after the result is taken.
// Reset: the bucket head memory is cleared one entry at a time after reset;
//   s_axis_tready stays low until the clearing is done.
// Stall: a result holds on m_axis until taken; no new request is accepted
//   meanwhile.
// ----------------------------------------------------------------------------
module chained_hash_map_unit #(
	parameter int MAX_BUCKETS = 256,
	parameter int POOL_NODES  = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [1:0] opcode, [32:2] lookup_key, [64:33] new_value, zero fill
	input  logic [71:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [1:0] status, [33:2] found_value, zero fill
	output logic [39:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [8:0]  cfg_data
);
	import chm_pkg::*;

	localparam int CW = $clog2(MAX_BUCKETS + 1);

	logic [8:0]    bcount_q;
	logic [CW-1:0] eff_n;
	mod_ctl_t      mod_ctl;
	logic          mod_busy, mod_done;
	logic [CW-1:0] mod_rem;
	logic [1:0]    st;
	logic [31:0]   fv;

	// bucket count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) bcount_q <= 9'd256;
		else if (cfg_valid && cfg_ready) bcount_q <= cfg_data;
	end
	assign cfg_ready = 1'b1;

	// clamp to 1..MAX_BUCKETS
	always_comb begin
		if (bcount_q == '0) eff_n = CW'(1);
		else if (32'(bcount_q) > MAX_BUCKETS) eff_n = CW'(MAX_BUCKETS);
		else eff_n = CW'(bcount_q);
	end

	chm_mod #(.DivW(CW)) u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_ctl.start),
		.dividend  (s_axis_tdata[32:2]),
		.divisor   (eff_n),
		.busy      (mod_busy),
		.done      (mod_done),
		.remainder (mod_rem)
	);

	chm_ctrl #(.MaxBuckets(MAX_BUCKETS), .PoolNodes(POOL_NODES)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_op      (s_axis_tdata[1:0]),
		.in_key     (s_axis_tdata[32:2]),
		.in_val     (s_axis_tdata[64:33]),
		.mod_ctl    (mod_ctl),
		.mod_busy   (mod_busy),
		.mod_done   (mod_done),
		.mod_rem    (mod_rem),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_status (st),
		.out_value  (fv)
	);

	assign m_axis_tdata = {6'd0, fv, st};

`ifndef SYNTHESIS
	a_nop_mod: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |-> !mod_busy)
		else $error("request accepted while modulo busy");
	a_out_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("request taken while result pending");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
		else $error("bad status code");
`endif

endmodule
